### rtl/bsc_pkg.sv
// Shared types, constants and the arctangent table of the bearing sector classifier.
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int TABLE_FRAC      = 20;
  localparam int UNIT_SHIFT      = TABLE_FRAC - 4 - ANGLE_FRAC_BITS;
  localparam int ITER_W          = $clog2(CORDIC_STEPS);

  // Vector, angle accumulator and bearing widths
  localparam int UV_W = 32;
  localparam int Z_W  = 29;
  localparam int B_W  = 24;

  // Port widths
  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 12;
  localparam int LAT_W      = 28;
  localparam int LON_W      = 29;
  localparam int HDG_W      = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AHEAD_HALF_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LIMIT       = 1'd1;
  localparam logic [CFG_W-1:0]     AHEAD_RESET = 12'd160;
  localparam logic [CFG_W-1:0]     SIDE_RESET  = 12'd1440;

  typedef logic [2:0] sector_t;
  localparam sector_t SEC_FAR_LEFT  = 3'd0;
  localparam sector_t SEC_LEFT      = 3'd1;
  localparam sector_t SEC_AHEAD     = 3'd2;
  localparam sector_t SEC_RIGHT     = 3'd3;
  localparam sector_t SEC_FAR_RIGHT = 3'd4;
  localparam sector_t SEC_ERROR     = 3'd5;

  localparam logic signed [Z_W-1:0] Z_QUARTER  = Z_W'(90 * (1 << TABLE_FRAC));
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1 << (UNIT_SHIFT - 1));
  localparam logic signed [B_W-1:0] DEG_180    = B_W'(180 * (1 << (4 + ANGLE_FRAC_BITS)));
  localparam logic signed [B_W-1:0] DEG_360    = B_W'(360 * (1 << (4 + ANGLE_FRAC_BITS)));

  typedef struct packed {
    logic load;
    logic pre;
    logic iter;
    logic round;
    logic wrap;
    logic finish;
  } bsc_cmd_t;

  typedef struct packed {
    logic fix_ok;
    logic last_iter;
    logic out_busy;
  } bsc_status_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [Z_W-1:0] atan_step(input logic [ITER_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    r = '0;
    case (int'(idx))
      0:  r = Z_W'(47185920);
      1:  r = Z_W'(27855475);
      2:  r = Z_W'(14718068);
      3:  r = Z_W'(7471121);
      4:  r = Z_W'(3750058);
      5:  r = Z_W'(1876857);
      6:  r = Z_W'(938658);
      7:  r = Z_W'(469357);
      8:  r = Z_W'(234682);
      9:  r = Z_W'(117342);
      10: r = Z_W'(58671);
      11: r = Z_W'(29335);
      12: r = Z_W'(14668);
      13: r = Z_W'(7334);
      14: r = Z_W'(3667);
      15: r = Z_W'(1833);
      16: r = Z_W'(917);
      17: r = Z_W'(458);
      18: r = Z_W'(229);
      19: r = Z_W'(115);
      20: r = Z_W'(57);
      21: r = Z_W'(29);
      22: r = Z_W'(14);
      23: r = Z_W'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/bsc_ctrl.sv
// Sequencer of the bearing sector classifier: load, pre-rotate, iterate, round, wrap, finish.
`timescale 1ns / 1ps
module bsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  bsc_pkg::bsc_status_t status,
  output bsc_pkg::bsc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRE    = 3'd1;
  localparam logic [2:0] S_ITER   = 3'd2;
  localparam logic [2:0] S_ROUND  = 3'd3;
  localparam logic [2:0] S_WRAP   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        // skip the angle work when a fix is missing
        if (status.fix_ok) begin
          cmd.pre    = 1'b1;
          state_next = S_ITER;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (status.last_iter) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bsc_dp.sv
// Datapath of the bearing sector classifier: CORDIC atan2, bearing wrap, sector binning.
`timescale 1ns / 1ps
module bsc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]            cfg_data,
  input  logic [bsc_pkg::IN_DATA_W-1:0]        s_tdata,
  input  logic [bsc_pkg::IN_USER_W-1:0]        s_tuser,
  input  bsc_pkg::bsc_cmd_t                    cmd,
  output bsc_pkg::bsc_status_t                 status,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bsc_pkg::OUT_DATA_W-1:0]       m_tdata
);

  localparam int UV_W = bsc_pkg::UV_W;
  localparam int Z_W  = bsc_pkg::Z_W;
  localparam int B_W  = bsc_pkg::B_W;

  logic [bsc_pkg::CFG_W-1:0] ahead_half_width;
  logic [bsc_pkg::CFG_W-1:0] side_limit;

  logic signed [UV_W-1:0] u;
  logic signed [UV_W-1:0] v;
  logic signed [Z_W-1:0]  z;
  logic                   zero_vec;
  logic                   fix_ok;
  logic [bsc_pkg::ITER_W-1:0] iter_cnt;
  logic [bsc_pkg::HDG_W-1:0]  heading;
  logic signed [B_W-1:0]  az;
  logic signed [B_W-1:0]  bear;

  bsc_pkg::sector_t shown_sector;
  bsc_pkg::sector_t pending_sector;
  bsc_pkg::sector_t shown_next;
  bsc_pkg::sector_t pending_next;
  bsc_pkg::sector_t sector_calc;
  bsc_pkg::sector_t out_sector;

  // Input field slices
  logic signed [bsc_pkg::LAT_W-1:0] my_lat, other_lat;
  logic signed [bsc_pkg::LON_W-1:0] my_lon, other_lon;
  logic signed [bsc_pkg::LAT_W:0]   dlat;
  logic signed [bsc_pkg::LON_W:0]   dlon;

  assign my_lat    = s_tdata[27:0];
  assign my_lon    = s_tdata[56:28];
  assign other_lat = s_tdata[84:57];
  assign other_lon = s_tdata[113:85];
  assign dlat = (bsc_pkg::LAT_W+1)'(other_lat) - (bsc_pkg::LAT_W+1)'(my_lat);
  assign dlon = (bsc_pkg::LON_W+1)'(other_lon) - (bsc_pkg::LON_W+1)'(my_lon);

  always_ff @(posedge clk) begin
    if (rst) begin
      ahead_half_width <= bsc_pkg::AHEAD_RESET;
      side_limit       <= bsc_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsc_pkg::REG_AHEAD_HALF_WIDTH: ahead_half_width <= cfg_data;
        bsc_pkg::REG_SIDE_LIMIT:       side_limit       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // CORDIC step terms
  logic signed [UV_W-1:0] du, dv;
  assign du = v >>> iter_cnt;
  assign dv = u >>> iter_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cnt <= '0;
      fix_ok   <= 1'b0;
    end else if (cmd.load) begin
      iter_cnt <= '0;
      fix_ok   <= s_tuser[0] & s_tuser[1];
    end else if (cmd.iter) begin
      iter_cnt <= iter_cnt + bsc_pkg::ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u       <= UV_W'(dlat);
      v       <= UV_W'(dlon);
      z       <= '0;
      heading <= s_tdata[126:114];
    end else if (cmd.pre) begin
      zero_vec <= (u == '0) && (v == '0);
      // rotate the left half-plane into the right one
      if (u < 0) begin
        if (v >= 0) begin
          u <= v;
          v <= -u;
          z <= bsc_pkg::Z_QUARTER;
        end else begin
          u <= -v;
          v <= u;
          z <= -bsc_pkg::Z_QUARTER;
        end
      end
    end else if (cmd.iter) begin
      if (v > 0) begin
        u <= u + du;
        v <= v - dv;
        z <= z + bsc_pkg::atan_step(iter_cnt);
      end else begin
        u <= u - du;
        v <= v + dv;
        z <= z - bsc_pkg::atan_step(iter_cnt);
      end
    end
  end

  // Round the azimuth to the bearing unit and bring it into [0, 360)
  logic signed [Z_W-1:0] z_sel, z_rnd;
  logic signed [B_W-1:0] az_raw;
  assign z_sel  = zero_vec ? bsc_pkg::Z_QUARTER : z;
  assign z_rnd  = (z_sel + bsc_pkg::ROUND_HALF) >>> bsc_pkg::UNIT_SHIFT;
  assign az_raw = B_W'(z_rnd);

  // Subtract heading, wrap once each way
  logic signed [B_W-1:0] hd, b0, b1, b2;
  assign hd = B_W'(heading) << bsc_pkg::ANGLE_FRAC_BITS;
  assign b0 = az - hd;
  assign b1 = (b0 < -bsc_pkg::DEG_180) ? b0 + bsc_pkg::DEG_360 : b0;
  assign b2 = (b1 > bsc_pkg::DEG_180) ? b1 - bsc_pkg::DEG_360 : b1;

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      az <= (az_raw < 0) ? az_raw + bsc_pkg::DEG_360 : az_raw;
    end
    if (cmd.wrap) begin
      bear <= b2;
    end
  end

  // Sector binning, first matching test wins
  logic signed [B_W-1:0] a_lim, s_lim;
  assign a_lim = B_W'(ahead_half_width) << bsc_pkg::ANGLE_FRAC_BITS;
  assign s_lim = B_W'(side_limit) << bsc_pkg::ANGLE_FRAC_BITS;

  always_comb begin
    if (bear <= -s_lim) begin
      sector_calc = bsc_pkg::SEC_FAR_LEFT;
    end else if (bear < -a_lim && bear > -s_lim) begin
      sector_calc = bsc_pkg::SEC_LEFT;
    end else if (bear <= a_lim && bear >= -a_lim) begin
      sector_calc = bsc_pkg::SEC_AHEAD;
    end else if (bear > a_lim && bear < s_lim) begin
      sector_calc = bsc_pkg::SEC_RIGHT;
    end else if (bear >= s_lim) begin
      sector_calc = bsc_pkg::SEC_FAR_RIGHT;
    end else begin
      sector_calc = bsc_pkg::SEC_ERROR;
    end
  end

  // Debounce: a new sector shows after two results in a row
  always_comb begin
    shown_next   = shown_sector;
    pending_next = pending_sector;
    if (sector_calc == shown_sector) begin
      pending_next = shown_sector;
    end else if (sector_calc == pending_sector) begin
      shown_next = sector_calc;
    end else begin
      pending_next = sector_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_sector   <= bsc_pkg::SEC_ERROR;
      pending_sector <= bsc_pkg::SEC_ERROR;
    end else if (cmd.finish && fix_ok) begin
      shown_sector   <= shown_next;
      pending_sector <= pending_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sector <= fix_ok ? shown_next : bsc_pkg::SEC_ERROR;
    end
  end

  assign m_tdata = bsc_pkg::OUT_DATA_W'(out_sector);

  assign status.fix_ok    = fix_ok;
  assign status.last_iter = (iter_cnt == bsc_pkg::ITER_W'(bsc_pkg::CORDIC_STEPS - 1));
  assign status.out_busy  = m_tvalid && !m_tready;

endmodule

### rtl/bearing_sector_classifier_top.sv
// Top level of the bearing sector classifier: controller, datapath and checks.
//
//   channel | direction | contents
//   s_*     | in        | tdata: my_lat, my_lon, other_lat, other_lon, own_heading, pad
//           |           | tuser: my_fix, other_fix
//   m_*     | out       | tdata: sector, pad
//   cfg_*   | in        | 0 ahead_half_width, 1 side_limit
//
// One item at a time: accept, pre-rotation, CORDIC_STEPS CORDIC iterations
// (16), round, wrap and finish run in that order before the next accept;
// the result is registered at finish. An item without both fixes skips
// from pre-rotation straight to finish.
// The shared CORDIC iteration unit sets the rate.
// Reset is synchronous; registers return to 160 and 1440, sectors to error.
// A stalled result stays in the output register; finish waits for it to drain.
`timescale 1ns / 1ps
module bearing_sector_classifier_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // my_lat[27:0], my_lon[56:28], other_lat[84:57], other_lon[113:85],
  // own_heading[126:114], zero pad[127]
  input  logic [bsc_pkg::IN_DATA_W-1:0]        s_tdata,
  // my_fix[0], other_fix[1]
  input  logic [bsc_pkg::IN_USER_W-1:0]        s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // sector[2:0], zero pad[7:3]
  output logic [bsc_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  logic                                 cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]            cfg_data
);

  bsc_pkg::bsc_cmd_t    cmd;
  bsc_pkg::bsc_status_t status;

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(m_tvalid && !m_tready))
    else $error("result written over a stalled result");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.pre, cmd.iter, cmd.round, cmd.wrap, cmd.finish}))
    else $error("more than one datapath command at once");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= bsc_pkg::SEC_ERROR))
    else $error("sector code out of range");

endmodule
